FILE: hdl/scbpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbpa_pkg
// Shared types, constants and helpers of the size-class block pool allocator.
// ----------------------------------------------------------------------------
package scbpa_pkg;

   // Geometry
   localparam int NUM_POOLS       = 4;
   localparam int BLOCKS_PER_POOL = 16;
   localparam int POOL_W          = $clog2(NUM_POOLS);
   localparam int BLK_W           = $clog2(BLOCKS_PER_POOL);
   localparam int CNT_W           = $clog2(BLOCKS_PER_POOL + 1);
   localparam int RING_DEPTH      = NUM_POOLS * BLOCKS_PER_POOL;
   localparam int ADDR_W          = POOL_W + BLK_W;

   // Datapath widths
   localparam int SIZE_W  = 16;
   localparam int BYTES_W = 22;
   localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_CLASS_SIZE_0  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BLOCKS_0 = 3'd4;

   // Reset values of the class sizes, pool 0 in the low slice
   localparam logic [NUM_POOLS-1:0][SIZE_W-1:0] SIZE_RESET =
      {16'd1024, 16'd256, 16'd64, 16'd16};

   typedef enum logic {
      OP_ALLOC   = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_NO_SPACE   = 2'd1,
      ST_BAD_HANDLE = 2'd2,
      ST_NOT_IN_USE = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic              op;
      logic [SIZE_W-1:0] request_length;
      logic [1:0]        release_pool;
      logic [3:0]        release_block;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [1:0]         granted_pool;
      logic [3:0]         granted_block;
      logic [4:0]         pool_blocks_in_use;
      logic [BYTES_W-1:0] bytes_now_used;
      logic [BYTES_W-1:0] bytes_peak;
   } rsp_type;

   // Result of the first-fit scan
   typedef struct packed {
      logic              hit;
      logic [POOL_W-1:0] pool;
   } fit_type;

   // Clamp a configured block count to the pool capacity
   function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cnt);
      logic [CNT_W-1:0] cap;
      cap = CNT_W'(BLOCKS_PER_POOL);
      return (cnt > cap) ? cap : cnt;
   endfunction

   // Free blocks left in a pool, zero when the count dropped below taken
   function automatic logic [CNT_W-1:0] free_count(input logic [CNT_W-1:0] cnt,
                                                   input logic [CNT_W-1:0] taken);
      logic [CNT_W-1:0] e;
      e = eff_count(cnt);
      return (e > taken) ? (e - taken) : '0;
   endfunction

endpackage

FILE: hdl/scbpa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbpa_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module scbpa_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, then register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/scbpa_fit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbpa_fit
// First-fit scan: lowest pool whose block size covers the length and that
// still has a free block.
// ----------------------------------------------------------------------------
module scbpa_fit (
   input  logic [scbpa_pkg::SIZE_W-1:0]                           length,
   input  logic [scbpa_pkg::NUM_POOLS-1:0][scbpa_pkg::SIZE_W-1:0] class_size,
   input  logic [scbpa_pkg::NUM_POOLS-1:0][scbpa_pkg::CNT_W-1:0]  pool_blocks,
   input  logic [scbpa_pkg::NUM_POOLS-1:0][scbpa_pkg::CNT_W-1:0]  taken,
   output scbpa_pkg::fit_type                                     fit
);

   logic [scbpa_pkg::NUM_POOLS-1:0] cand;

   // Flag every pool that could serve the length
   always_comb begin
      for (int p = 0; p < scbpa_pkg::NUM_POOLS; p++) begin
         cand[p] = (length <= class_size[p]) &&
                   (scbpa_pkg::free_count(pool_blocks[p], taken[p]) != '0);
      end
   end

   // Pick the lowest flagged pool
   always_comb begin
      fit.hit  = 1'b0;
      fit.pool = '0;
      for (int p = scbpa_pkg::NUM_POOLS - 1; p >= 0; p--) begin
         if (cand[p]) begin
            fit.hit  = 1'b1;
            fit.pool = scbpa_pkg::POOL_W'(p);
         end
      end
   end

endmodule

FILE: hdl/size_class_block_pool_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_block_pool_allocator_top
// Segregated fixed-block pool allocator with first-fit over four size classes.
// ----------------------------------------------------------------------------
// Usage:
//   Present an item on req_item and raise start; it is taken on a clock edge
//   where busy is low. op selects allocate (request_length used) or release
//   (release_pool / release_block used).
//   Each item is handled in the accept cycle, which scans the pools and reads
//   the free-ring and busy-mark memories, and then in the exec state, which
//   decides and writes them back. The result is registered at the end of the
//   exec state and appears on rsp_item with rsp_valid high for exactly one
//   cycle. busy is high during the exec state, so no new item is taken while
//   one is in progress; the next item may be taken in the cycle its
//   predecessor's result is shown. The receiver cannot stall.
//   Configuration (class sizes at indexes 0..3, block counts at 4..7) is
//   written through csr_we / csr_addr / csr_wdata while the block is idle.
//   Synchronous reset restores the default sizes and counts, returns every
//   block to its pool and clears the byte counters; busy stays high while
//   reset is held. No clearing pass is needed, the memories start valid
//   through per-entry valid bits.
// ----------------------------------------------------------------------------
module size_class_block_pool_allocator_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  scbpa_pkg::req_type                  req_item,
   output logic                                rsp_valid,
   output scbpa_pkg::rsp_type                  rsp_item,
   input  logic                                csr_we,
   input  logic [scbpa_pkg::CSR_IDX_W-1:0]     csr_addr,
   input  logic [scbpa_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int NP = scbpa_pkg::NUM_POOLS;
   localparam int PW = scbpa_pkg::POOL_W;
   localparam int BW = scbpa_pkg::BLK_W;
   localparam int CW = scbpa_pkg::CNT_W;
   localparam int SW = scbpa_pkg::SIZE_W;
   localparam int YW = scbpa_pkg::BYTES_W;
   localparam int AW = scbpa_pkg::ADDR_W;
   localparam int RD = scbpa_pkg::RING_DEPTH;

   // Control
   scbpa_pkg::state_type state_ff, state_in;
   logic accept, exec_en;

   // Configuration and pool bookkeeping
   logic [NP-1:0][SW-1:0] size_ff;
   logic [NP-1:0][CW-1:0] blocks_ff;
   logic [NP-1:0][BW-1:0] head_ff, head_in;
   logic [NP-1:0][CW-1:0] taken_ff, taken_in;
   logic [YW-1:0]         used_ff, used_in, peak_ff, peak_in;
   logic [RD-1:0]         ring_vld_ff, busy_vld_ff;

   // Captured item
   scbpa_pkg::req_type req_ff;
   logic               hit_ff, bad_ff, ring_vq_ff, busy_vq_ff;
   logic [PW-1:0]      pool_ff;

   // Result
   logic               rsp_valid_ff;
   scbpa_pkg::rsp_type rsp_ff, rsp_in;

   // Memory ports
   scbpa_pkg::fit_type fit;
   logic [PW-1:0] pool_sel;
   logic [AW-1:0] ring_raddr, busy_raddr, ring_waddr, busy_waddr;
   logic [BW-1:0] ring_rdata, ring_wdata;
   logic          busy_rdata, busy_wdata, ring_we, busy_we;

   // Exec-cycle helpers
   logic [BW-1:0] cur_head, tail, alloc_blk;
   logic [CW-1:0] cur_taken;
   logic [SW-1:0] sel_size;
   logic [YW:0]   add_sum;
   logic [YW-1:0] add_sat, sub_val;
   logic          busy_bit;
   logic [PW-1:0] csr_pool;

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         scbpa_pkg::S_IDLE: begin
            if (start) state_in = scbpa_pkg::S_EXEC;
         end
         scbpa_pkg::S_EXEC: state_in = scbpa_pkg::S_IDLE;
         default:           state_in = scbpa_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      busy    = 1'b1;
      accept  = 1'b0;
      exec_en = 1'b0;
      case (state_ff)
         scbpa_pkg::S_IDLE: begin
            busy   = reset;
            accept = start & ~reset;
         end
         scbpa_pkg::S_EXEC: exec_en = 1'b1;
         default:           busy = 1'b1;
      endcase
   end

   // ------------------------------------------------------------------
   // Scan and memory reads in the accept cycle
   // ------------------------------------------------------------------
   scbpa_fit u_fit (
      .length      (req_item.request_length),
      .class_size  (size_ff),
      .pool_blocks (blocks_ff),
      .taken       (taken_ff),
      .fit         (fit)
   );

   assign pool_sel   = (req_item.op == scbpa_pkg::OP_ALLOC) ? fit.pool
                                                            : req_item.release_pool;
   assign ring_raddr = {fit.pool, head_ff[fit.pool]};
   assign busy_raddr = {req_item.release_pool, req_item.release_block};

   scbpa_ram #(.WIDTH(BW), .DEPTH(RD)) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_waddr),
      .wr_data (ring_wdata),
      .rd_addr (ring_raddr),
      .rd_data (ring_rdata)
   );

   scbpa_ram #(.WIDTH(1), .DEPTH(RD)) u_busy (
      .clock   (clock),
      .wr_en   (busy_we),
      .wr_addr (busy_waddr),
      .wr_data (busy_wdata),
      .rd_addr (busy_raddr),
      .rd_data (busy_rdata)
   );

   // ------------------------------------------------------------------
   // Decide and write back in the exec cycle
   // ------------------------------------------------------------------
   assign cur_head  = head_ff[pool_ff];
   assign cur_taken = taken_ff[pool_ff];
   assign sel_size  = size_ff[pool_ff];
   // entry never written still holds its reset block number
   assign alloc_blk = ring_vq_ff ? ring_rdata : cur_head;
   assign busy_bit  = busy_vq_ff & busy_rdata;
   assign tail      = cur_head +
                      BW'(scbpa_pkg::free_count(blocks_ff[pool_ff], cur_taken));
   assign add_sum   = {1'b0, used_ff} + (YW + 1)'(sel_size);
   assign add_sat   = add_sum[YW] ? scbpa_pkg::BYTES_MAX : add_sum[YW-1:0];
   assign sub_val   = (used_ff > YW'(sel_size)) ? (used_ff - YW'(sel_size)) : '0;

   always_comb begin
      head_in    = head_ff;
      taken_in   = taken_ff;
      used_in    = used_ff;
      peak_in    = peak_ff;
      ring_we    = 1'b0;
      ring_waddr = {pool_ff, tail};
      ring_wdata = req_ff.release_block;
      busy_we    = 1'b0;
      busy_waddr = {pool_ff, alloc_blk};
      busy_wdata = 1'b1;

      rsp_in                    = '0;
      rsp_in.status             = scbpa_pkg::ST_NO_SPACE;
      rsp_in.bytes_now_used     = used_ff;
      rsp_in.bytes_peak         = peak_ff;

      if (exec_en) begin
         if (req_ff.op == scbpa_pkg::OP_ALLOC) begin
            // pop the head of the chosen pool
            if (hit_ff) begin
               head_in[pool_ff]  = cur_head + BW'(1);
               taken_in[pool_ff] = cur_taken + CW'(1);
               used_in           = add_sat;
               peak_in           = (add_sat > peak_ff) ? add_sat : peak_ff;
               busy_we           = 1'b1;
               rsp_in.status             = scbpa_pkg::ST_OK;
               rsp_in.granted_pool       = pool_ff;
               rsp_in.granted_block      = alloc_blk;
               rsp_in.pool_blocks_in_use = cur_taken + CW'(1);
               rsp_in.bytes_now_used     = add_sat;
               rsp_in.bytes_peak         = (add_sat > peak_ff) ? add_sat : peak_ff;
            end
         end else begin
            rsp_in.granted_pool       = req_ff.release_pool;
            rsp_in.granted_block      = req_ff.release_block;
            rsp_in.pool_blocks_in_use = cur_taken;
            busy_waddr                = {pool_ff, req_ff.release_block};
            busy_wdata                = 1'b0;
            if (bad_ff) begin
               rsp_in.status = scbpa_pkg::ST_BAD_HANDLE;
            end else if (!busy_bit) begin
               rsp_in.status = scbpa_pkg::ST_NOT_IN_USE;
            end else begin
               // push the block on the tail of its ring
               ring_we = 1'b1;
               busy_we = 1'b1;
               taken_in[pool_ff] = (cur_taken != '0) ? cur_taken - CW'(1) : '0;
               used_in           = sub_val;
               rsp_in.status             = scbpa_pkg::ST_OK;
               rsp_in.pool_blocks_in_use = (cur_taken != '0) ? cur_taken - CW'(1) : '0;
               rsp_in.bytes_now_used     = sub_val;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   assign csr_pool = PW'(csr_addr - scbpa_pkg::CSR_POOL_BLOCKS_0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scbpa_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         size_ff      <= scbpa_pkg::SIZE_RESET;
         blocks_ff    <= {NP{CW'(scbpa_pkg::BLOCKS_PER_POOL)}};
         head_ff      <= '0;
         taken_ff     <= '0;
         used_ff      <= '0;
         peak_ff      <= '0;
         ring_vld_ff  <= '0;
         busy_vld_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= exec_en;
         head_ff      <= head_in;
         taken_ff     <= taken_in;
         used_ff      <= used_in;
         peak_ff      <= peak_in;
         if (ring_we) ring_vld_ff[ring_waddr] <= 1'b1;
         if (busy_we) busy_vld_ff[busy_waddr] <= 1'b1;
         // configuration write
         if (csr_we) begin
            if (csr_addr < scbpa_pkg::CSR_POOL_BLOCKS_0) begin
               size_ff[PW'(csr_addr - scbpa_pkg::CSR_CLASS_SIZE_0)] <= csr_wdata;
            end else begin
               blocks_ff[csr_pool] <= csr_wdata[CW-1:0];
            end
         end
      end
   end

   // Capture the item and its scan result; track valid bits of the reads
   always_ff @(posedge clock) begin
      ring_vq_ff <= ring_vld_ff[ring_raddr];
      busy_vq_ff <= busy_vld_ff[busy_raddr];
      rsp_ff     <= rsp_in;
      if (accept) begin
         req_ff  <= req_item;
         hit_ff  <= fit.hit;
         pool_ff <= pool_sel;
         bad_ff  <= ({1'b0, req_item.release_block} >=
                     scbpa_pkg::eff_count(blocks_ff[req_item.release_pool]));
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
